### rtl/mrd_pkg.sv
package mrd_pkg;

  // byte codes seen on the response stream
  localparam logic [7:0] CH_LF    = 8'h0A;
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_DOT   = 8'h2E;
  localparam logic [7:0] CH_BRACE = 8'h7B;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;

  // width of the size estimate on the result side
  localparam int unsigned EST_W = 32;

  typedef enum logic [2:0] {
    KIND_REPLY     = 3'd0,
    KIND_BEGIN_DOT = 3'd1,
    KIND_BEGIN_BIN = 3'd2,
    KIND_DATA      = 3'd3,
    KIND_END       = 3'd4
  } kind_e;

  // one result transaction
  typedef struct packed {
    kind_e            kind;
    logic [7:0]       value;
    logic [EST_W-1:0] est;
  } res_t;

  // all results caused by one input byte: one or two
  typedef struct packed {
    logic two;
    res_t r0;
    res_t r1;
  } pair_t;

endpackage

### rtl/mrd_front.sv
module mrd_front
  import mrd_pkg::*;
#(
  parameter int unsigned COUNT_BITS = 32
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       valid_i,
  input  logic [7:0] byte_i,
  input  logic       q_full_i,
  output logic       ready_o,
  output logic       q_push_o,
  output pair_t      q_data_o
);

  typedef enum logic [2:0] {
    M_REPLY,
    M_HEAD,
    M_HEAD_SKIP,
    M_DOT,
    M_BCOUNT,
    M_BDATA
  } mode_e;

  localparam int unsigned PW = COUNT_BITS + 4;

  mode_e                 mode_q, mode_d;
  logic                  line_start_q, line_start_d;
  logic                  dot_held_q, dot_held_d;
  logic                  cr_held_q, cr_held_d;
  logic [1:0]            phase_q, phase_d;
  logic [COUNT_BITS-1:0] acc_q, acc_d;
  logic [COUNT_BITS-1:0] chunk_q, chunk_d;
  logic [COUNT_BITS-1:0] remain_q, remain_d;
  logic                  digit_q, digit_d;

  logic        is_space, is_digit, is_lf, fin, take;
  logic [1:0]  n;
  pair_t       pair;

  // saturating decimal step: acc * 10 + digit
  function automatic logic [COUNT_BITS-1:0] add_digit(input logic [COUNT_BITS-1:0] acc,
                                                       input logic [7:0] c);
    logic [PW-1:0] prod;
    logic [3:0]    d;
    d    = 4'(c - CH_ZERO);
    prod = PW'({acc, 3'b000}) + PW'({acc, 1'b0}) + PW'(d);
    if (prod[PW-1 -: 4] != 4'd0) begin
      return '1;
    end
    return prod[COUNT_BITS-1:0];
  endfunction

  // estimate on the result side saturates at the port width
  function automatic logic [EST_W-1:0] to_est(input logic [COUNT_BITS-1:0] v);
    logic [PW-1:0] w;
    w = PW'(v);
    if ((w >> EST_W) != '0) begin
      return '1;
    end
    return EST_W'(v);
  endfunction

  function automatic res_t mk(input kind_e k, input logic [7:0] v, input logic [EST_W-1:0] e);
    res_t r;
    r.kind  = k;
    r.value = v;
    r.est   = e;
    return r;
  endfunction

  assign is_lf    = (byte_i == CH_LF);
  assign is_space = (byte_i == CH_SPACE) || (byte_i >= CH_TAB && byte_i <= CH_CR);
  assign is_digit = (byte_i >= CH_ZERO) && (byte_i <= CH_NINE);

  assign ready_o  = !q_full_i;
  assign take     = valid_i && !q_full_i;
  assign q_push_o = take && (n != 2'd0);
  assign q_data_o = pair;

  // classify one byte and work out the next state and its results
  always_comb begin
    mode_d       = mode_q;
    line_start_d = line_start_q;
    dot_held_d   = dot_held_q;
    cr_held_d    = cr_held_q;
    phase_d      = phase_q;
    acc_d        = acc_q;
    chunk_d      = chunk_q;
    remain_d     = remain_q;
    digit_d      = digit_q;
    fin          = 1'b0;
    n            = 2'd0;
    pair         = '0;

    unique case (mode_q)
      M_HEAD, M_HEAD_SKIP: begin
        // header word parsing
        if (mode_q == M_HEAD) begin
          if (is_space) begin
            fin = 1'b1;
          end else if (phase_d == 2'd0 && byte_i == CH_DOT) begin
            phase_d = 2'd1;
          end else begin
            if (phase_d == 2'd0) begin
              phase_d = 2'd2;
            end
            if (is_digit) begin
              acc_d   = add_digit(acc_d, byte_i);
              digit_d = 1'b1;
            end else if (phase_d == 2'd2 && digit_d) begin
              chunk_d = acc_d;
              acc_d   = '0;
              digit_d = 1'b0;
              phase_d = 2'd3;
            end else begin
              fin = 1'b1;
            end
          end
        end
        // end of the header word settles first chunk and estimate
        if (fin) begin
          if (phase_d == 2'd0) begin
            phase_d = 2'd2;
            chunk_d = '0;
            acc_d   = '0;
          end else if (phase_d == 2'd2) begin
            chunk_d = digit_d ? acc_d : '0;
            acc_d   = '0;
          end
          mode_d = M_HEAD_SKIP;
        end
        // line feed announces the data
        if (is_lf) begin
          if (phase_d == 2'd1) begin
            pair.r0 = mk(KIND_BEGIN_DOT, 8'h00, to_est(acc_d));
            mode_d  = M_DOT;
          end else begin
            pair.r0  = mk(KIND_BEGIN_BIN, 8'h00, to_est(acc_d));
            remain_d = chunk_d;
            if (chunk_d == '0) begin
              mode_d = M_BCOUNT;
            end else begin
              mode_d = M_BDATA;
            end
          end
          n            = 2'd1;
          line_start_d = 1'b1;
          dot_held_d   = 1'b0;
          cr_held_d    = 1'b0;
          phase_d      = 2'd0;
          acc_d        = '0;
          digit_d      = 1'b0;
        end
      end

      M_DOT: begin
        if (is_lf) begin
          if (dot_held_q) begin
            pair.r0      = mk(KIND_END, 8'h00, '0);
            n            = 2'd1;
            mode_d       = M_REPLY;
            line_start_d = 1'b1;
            dot_held_d   = 1'b0;
            cr_held_d    = 1'b0;
            phase_d      = 2'd0;
            acc_d        = '0;
            digit_d      = 1'b0;
            remain_d     = '0;
          end else begin
            cr_held_d    = 1'b0;
            pair.r0      = mk(KIND_DATA, byte_i, '0);
            n            = 2'd1;
            line_start_d = 1'b1;
          end
        end else begin
          // a held cr not followed by lf goes out first
          if (cr_held_q) begin
            pair.r0    = mk(KIND_DATA, CH_CR, '0);
            n          = 2'd1;
            cr_held_d  = 1'b0;
            dot_held_d = 1'b0;
          end
          if (byte_i == CH_CR) begin
            cr_held_d    = 1'b1;
            line_start_d = 1'b0;
          end else if (line_start_q && byte_i == CH_DOT) begin
            dot_held_d   = 1'b1;
            line_start_d = 1'b0;
          end else begin
            if (n == 2'd0) begin
              pair.r0 = mk(KIND_DATA, byte_i, '0);
            end else begin
              pair.r1  = mk(KIND_DATA, byte_i, '0);
              pair.two = 1'b1;
            end
            n            = n + 2'd1;
            dot_held_d   = 1'b0;
            line_start_d = 1'b0;
          end
        end
      end

      M_BCOUNT: begin
        if (is_lf) begin
          if (!digit_q || acc_q == '0) begin
            pair.r0      = mk(KIND_END, 8'h00, '0);
            n            = 2'd1;
            mode_d       = M_REPLY;
            line_start_d = 1'b1;
            dot_held_d   = 1'b0;
            cr_held_d    = 1'b0;
            remain_d     = '0;
          end else begin
            remain_d = acc_q;
            mode_d   = M_BDATA;
          end
          phase_d = 2'd0;
          acc_d   = '0;
          digit_d = 1'b0;
        end else if (phase_q == 2'd2) begin
          // rest of the count line ignored
        end else if (is_digit) begin
          acc_d   = add_digit(acc_q, byte_i);
          digit_d = 1'b1;
          phase_d = 2'd1;
        end else if (!(phase_q == 2'd0 && is_space)) begin
          phase_d = 2'd2;
        end
      end

      M_BDATA: begin
        pair.r0 = mk(KIND_DATA, byte_i, '0);
        n       = 2'd1;
        if (remain_q > COUNT_BITS'(1)) begin
          remain_d = remain_q - COUNT_BITS'(1);
        end else begin
          remain_d = '0;
          mode_d   = M_BCOUNT;
          phase_d  = 2'd0;
          acc_d    = '0;
          digit_d  = 1'b0;
        end
      end

      default: begin
        // reply line
        if (is_lf) begin
          pair.r0      = mk(KIND_REPLY, byte_i, '0);
          n            = 2'd1;
          line_start_d = 1'b1;
        end else if (line_start_q && is_space) begin
          // leading whitespace dropped
        end else if (line_start_q && byte_i == CH_BRACE) begin
          mode_d       = M_HEAD;
          phase_d      = 2'd0;
          acc_d        = '0;
          chunk_d      = '0;
          digit_d      = 1'b0;
          line_start_d = 1'b0;
        end else begin
          pair.r0      = mk(KIND_REPLY, byte_i, '0);
          n            = 2'd1;
          line_start_d = 1'b0;
        end
      end
    endcase
  end

  // deframer state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q       <= M_REPLY;
      line_start_q <= 1'b1;
      dot_held_q   <= 1'b0;
      cr_held_q    <= 1'b0;
      phase_q      <= 2'd0;
      acc_q        <= '0;
      chunk_q      <= '0;
      remain_q     <= '0;
      digit_q      <= 1'b0;
    end else if (take) begin
      mode_q       <= mode_d;
      line_start_q <= line_start_d;
      dot_held_q   <= dot_held_d;
      cr_held_q    <= cr_held_d;
      phase_q      <= phase_d;
      acc_q        <= acc_d;
      chunk_q      <= chunk_d;
      remain_q     <= remain_d;
      digit_q      <= digit_d;
    end
  end

endmodule

### rtl/mrd_queue.sv
module mrd_queue
  import mrd_pkg::*;
(
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  wr_i,
  input  pair_t wr_data_i,
  output logic  full_o,
  input  logic  rd_i,
  output pair_t rd_data_o,
  output logic  empty_o
);

  localparam int unsigned DEPTH = 4;
  localparam int unsigned AW    = $clog2(DEPTH);

  pair_t         slot_q [DEPTH];
  logic [AW-1:0] wptr_q, rptr_q;
  logic [AW:0]   cnt_q;
  logic          do_wr, do_rd;

  assign full_o    = (cnt_q == (AW + 1)'(DEPTH));
  assign empty_o   = (cnt_q == '0);
  assign do_wr     = wr_i && !full_o;
  assign do_rd     = rd_i && !empty_o;
  assign rd_data_o = slot_q[rptr_q];

  // pointers and fill count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
      cnt_q  <= '0;
    end else begin
      if (do_wr) begin
        wptr_q <= wptr_q + AW'(1);
      end
      if (do_rd) begin
        rptr_q <= rptr_q + AW'(1);
      end
      if (do_wr && !do_rd) begin
        cnt_q <= cnt_q + (AW + 1)'(1);
      end else if (do_rd && !do_wr) begin
        cnt_q <= cnt_q - (AW + 1)'(1);
      end
    end
  end

  // storage
  always_ff @(posedge clk_i) begin
    if (do_wr) begin
      slot_q[wptr_q] <= wr_data_i;
    end
  end

endmodule

### rtl/mrd_back.sv
module mrd_back
  import mrd_pkg::*;
(
  input  logic             clk_i,
  input  logic             rst_ni,
  input  pair_t            q_data_i,
  input  logic             q_empty_i,
  output logic             q_pop_o,
  input  logic             pop,
  output logic             empty,
  output logic [2:0]       kind_o,
  output logic [7:0]       value_o,
  output logic [EST_W-1:0] size_estimate_o,
  output logic             last_o
);

  logic  valid_q;
  logic  idx_q;
  pair_t hold_q;
  res_t  cur;
  logic  is_last, drain, load;

  assign cur     = idx_q ? hold_q.r1 : hold_q.r0;
  assign is_last = idx_q || !hold_q.two;
  assign drain   = valid_q && pop;
  assign load    = (!valid_q || (drain && is_last)) && !q_empty_i;
  assign q_pop_o = load;

  assign empty           = !valid_q;
  assign kind_o          = cur.kind;
  assign value_o         = cur.value;
  assign size_estimate_o = cur.est;
  assign last_o          = is_last;

  // output holding register, steps through the one or two results of a pair
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
      idx_q   <= 1'b0;
    end else if (load) begin
      valid_q <= 1'b1;
      idx_q   <= 1'b0;
    end else if (drain) begin
      if (is_last) begin
        valid_q <= 1'b0;
        idx_q   <= 1'b0;
      end else begin
        idx_q <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      hold_q <= q_data_i;
    end
  end

endmodule

### rtl/mail_response_deframer_unit.sv
// Response stream deframer: takes one received byte per transaction and
// returns reply-line bytes, begin markers with size estimates, data bytes and
// end markers. A byte is taken every cycle while full is low; the front
// classifier updates its state in the same cycle and writes any results of
// the byte as a pair of one or two into a four-deep queue. The result side
// delivers one result per cycle while pop is high, so a byte that yields two
// results (a held CR released in front of the next dot-data byte) hands them
// out as two results in turn. A byte's results pass through the queue and
// then the output holding register before they appear on the result ports;
// full rises only when the queue of pairs is full.
module mail_response_deframer_unit
  import mrd_pkg::*;
#(
  parameter int unsigned COUNT_BITS = 32
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push,
  output logic             full,
  input  logic [7:0]       rx_byte_i,
  output logic             empty,
  input  logic             pop,
  output logic [2:0]       kind_o,
  output logic [7:0]       value_o,
  output logic [EST_W-1:0] size_estimate_o,
  output logic             last_o
);

  logic  ready, q_push, q_full, q_pop, q_empty;
  pair_t q_wdata, q_rdata;

  assign full = !ready;

  mrd_front #(
    .COUNT_BITS(COUNT_BITS)
  ) u_front (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (push),
    .byte_i  (rx_byte_i),
    .q_full_i(q_full),
    .ready_o (ready),
    .q_push_o(q_push),
    .q_data_o(q_wdata)
  );

  mrd_queue u_queue (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .wr_i     (q_push),
    .wr_data_i(q_wdata),
    .full_o   (q_full),
    .rd_i     (q_pop),
    .rd_data_o(q_rdata),
    .empty_o  (q_empty)
  );

  mrd_back u_back (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .q_data_i       (q_rdata),
    .q_empty_i      (q_empty),
    .q_pop_o        (q_pop),
    .pop            (pop),
    .empty          (empty),
    .kind_o         (kind_o),
    .value_o        (value_o),
    .size_estimate_o(size_estimate_o),
    .last_o         (last_o)
  );

endmodule
